// File: rtl/bhp_pkg.sv
`default_nettype none

package bhp_pkg;

  // Built depth of the pool and the widths that follow from it
  localparam int POOL_DEPTH = 64;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int ID_W       = 32;
  localparam int CMD_W      = 3;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
  localparam logic [ID_W-1:0]  BASE_RESET = 32'd1;

  // Source of the result fields
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_DONE = 2'd1,
    RES_ACQ  = 2'd2,
    RES_FIND = 2'd3
  } res_e;

  typedef struct packed {
    logic latch;
    logic acq_rd;
    logic acq_wr;
    logic scan;
    logic rel_rd;
    logic rel_wr;
    logic flush;
    logic clr_used;
    logic init;
    logic fin;
    res_e res;
  } ctrl_t;

  typedef struct packed {
    logic can_acq;
    logic used_empty;
    logic scan_hit;
    logic scan_end;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bhp_ctrl.sv
`default_nettype none

module bhp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic [bhp_pkg::CMD_W-1:0] command_i,
  input  bhp_pkg::status_t        status_i,
  output bhp_pkg::ctrl_t          ctrl_o,
  output logic                    busy
);
  import bhp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ACQ      = 7'b0000010,
    S_FIND     = 7'b0000100,
    S_REL_SCAN = 7'b0001000,
    S_REL_RD   = 7'b0010000,
    S_REL_WR   = 7'b0100000,
    S_FLUSH    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.res = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.latch = 1'b1;
          case (command_i)
            CMD_ACQUIRE: begin
              if (status_i.can_acq) begin
                ctrl_o.acq_rd = 1'b1;
                state_d = S_ACQ;
              end else begin
                ctrl_o.fin = 1'b1;
              end
            end
            CMD_FIND: begin
              if (status_i.used_empty) ctrl_o.fin = 1'b1;
              else state_d = S_FIND;
            end
            CMD_RELEASE: begin
              if (status_i.used_empty) ctrl_o.fin = 1'b1;
              else state_d = S_REL_SCAN;
            end
            CMD_FLUSH: begin
              if (status_i.used_empty) begin
                ctrl_o.fin = 1'b1;
                ctrl_o.res = RES_DONE;
              end else begin
                state_d = S_FLUSH;
              end
            end
            CMD_INIT: begin
              ctrl_o.init = 1'b1;
              ctrl_o.fin  = 1'b1;
              ctrl_o.res  = RES_DONE;
            end
            default: ctrl_o.fin = 1'b1;
          endcase
        end
      end
      S_ACQ: begin
        ctrl_o.acq_wr = 1'b1;
        ctrl_o.fin    = 1'b1;
        ctrl_o.res    = RES_ACQ;
        state_d = S_IDLE;
      end
      S_FIND: begin
        ctrl_o.scan = 1'b1;
        if (status_i.scan_hit) begin
          ctrl_o.fin = 1'b1;
          ctrl_o.res = RES_FIND;
          state_d = S_IDLE;
        end else if (status_i.scan_end) begin
          ctrl_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REL_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (status_i.scan_hit) begin
          state_d = S_REL_RD;
        end else if (status_i.scan_end) begin
          ctrl_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REL_RD: begin
        ctrl_o.rel_rd = 1'b1;
        state_d = S_REL_WR;
      end
      S_REL_WR: begin
        ctrl_o.rel_wr = 1'b1;
        ctrl_o.fin    = 1'b1;
        ctrl_o.res    = RES_DONE;
        state_d = S_IDLE;
      end
      S_FLUSH: begin
        ctrl_o.flush = 1'b1;
        if (status_i.scan_end) begin
          ctrl_o.clr_used = 1'b1;
          ctrl_o.fin      = 1'b1;
          ctrl_o.res      = RES_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/bhp_datapath.sv
`default_nettype none

module bhp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bhp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bhp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [bhp_pkg::ID_W-1:0]       handle_id_i,
  input  bhp_pkg::ctrl_t                ctrl_i,
  output bhp_pkg::status_t              status_o,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [bhp_pkg::ID_W-1:0]       out_id_o,
  output logic [bhp_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [bhp_pkg::CNT_W-1:0]      used_total_o,
  output logic [bhp_pkg::CNT_W-1:0]      free_total_o
);
  import bhp_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

  // Configuration
  logic [CAP_W-1:0] cap_q;
  logic [ID_W-1:0]  base_q;

  // Counters and per-entry valid bits of the free stack
  logic [CNT_W-1:0]      free_depth_q, free_depth_d;
  logic [CNT_W-1:0]      used_depth_q, used_depth_d;
  logic [POOL_DEPTH-1:0] free_vld_q, free_vld_d;

  // Memories
  logic [SLOT_W-1:0] free_mem [POOL_DEPTH];
  logic [SLOT_W-1:0] used_mem [POOL_DEPTH];

  logic [SLOT_W-1:0] free_rd_q, free_rd_addr_q;
  logic              free_rd_vld_q;
  logic [SLOT_W-1:0] used_rd_q;

  // Scan pipeline
  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0] hit_pos_q, hit_slot_q;

  logic              scan_go, hit;
  logic [CNT_W-1:0]  used_last, free_top, init_depth;
  logic [SLOT_W-1:0] acq_slot;

  logic              used_re, used_we;
  logic [SLOT_W-1:0] used_raddr, used_waddr, used_wdata;
  logic              push_en, free_we;
  logic [SLOT_W-1:0] push_slot;

  // Result
  logic              res_ok;
  logic [ID_W-1:0]   res_id;
  logic [SLOT_W-1:0] res_slot;
  logic              done_q, ok_q;
  logic [ID_W-1:0]   out_id_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  used_tot_q, free_tot_q;

  assign used_last  = used_depth_q - CNT_W'(1);
  assign free_top   = free_depth_q - CNT_W'(1);
  assign init_depth = (32'(cap_q) > 32'(POOL_DEPTH)) ? DEPTH_CNT : CNT_W'(cap_q);
  assign acq_slot   = free_rd_vld_q ? free_rd_q : free_rd_addr_q;
  assign hit        = cmp_vld_q && ((base_q + ID_W'(used_rd_q)) == id_q);
  assign scan_go    = (ctrl_i.scan || ctrl_i.flush) && (rd_idx_q < used_depth_q);

  assign status_o.can_acq    = (free_depth_q != '0) && (used_depth_q < DEPTH_CNT);
  assign status_o.used_empty = (used_depth_q == '0);
  assign status_o.scan_hit   = hit;
  assign status_o.scan_end   = !cmp_vld_q && (rd_idx_q >= used_depth_q);

  always_comb begin
    free_depth_d = free_depth_q;
    used_depth_d = used_depth_q;
    free_vld_d   = free_vld_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    used_re      = 1'b0;
    used_raddr   = rd_idx_q[SLOT_W-1:0];
    used_we      = 1'b0;
    used_waddr   = used_depth_q[SLOT_W-1:0];
    used_wdata   = acq_slot;
    push_en      = 1'b0;
    push_slot    = used_rd_q;

    if (ctrl_i.latch) rd_idx_d = '0;

    // Issue one used-list read per cycle, compare it the cycle after
    if (scan_go) begin
      used_re   = 1'b1;
      cmp_vld_d = 1'b1;
      cmp_idx_d = rd_idx_q[SLOT_W-1:0];
      rd_idx_d  = rd_idx_q + CNT_W'(1);
    end

    if (ctrl_i.rel_rd) begin
      used_re    = 1'b1;
      used_raddr = used_last[SLOT_W-1:0];
    end

    if (ctrl_i.acq_wr) begin
      used_we      = 1'b1;
      used_depth_d = used_depth_q + CNT_W'(1);
      free_depth_d = free_top;
    end

    // Move the last entry into the hole and return the freed slot
    if (ctrl_i.rel_wr) begin
      used_we      = 1'b1;
      used_waddr   = hit_pos_q;
      used_wdata   = used_rd_q;
      used_depth_d = used_last;
      push_en      = 1'b1;
      push_slot    = hit_slot_q;
    end

    if (ctrl_i.flush && cmp_vld_q) push_en = 1'b1;

    if (ctrl_i.clr_used) used_depth_d = '0;

    if (ctrl_i.init) begin
      free_vld_d   = '0;
      free_depth_d = init_depth;
      used_depth_d = '0;
    end

    free_we = push_en && (free_depth_q < DEPTH_CNT);
    if (free_we) begin
      free_vld_d[free_depth_q[SLOT_W-1:0]] = 1'b1;
      free_depth_d = free_depth_q + CNT_W'(1);
    end
  end

  always_comb begin
    case (ctrl_i.res)
      RES_ACQ: begin
        res_ok   = 1'b1;
        res_id   = base_q + ID_W'(acq_slot);
        res_slot = acq_slot;
      end
      RES_FIND: begin
        res_ok   = 1'b1;
        res_id   = id_q;
        res_slot = used_rd_q;
      end
      RES_DONE: begin
        res_ok   = 1'b1;
        res_id   = '0;
        res_slot = '0;
      end
      default: begin
        res_ok   = 1'b0;
        res_id   = '0;
        res_slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      base_q       <= BASE_RESET;
      free_depth_q <= DEPTH_CNT;
      used_depth_q <= '0;
      free_vld_q   <= '0;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CAPACITY) cap_q <= cfg_wdata_i[CAP_W-1:0];
        if (cfg_idx_i == REG_BASE)     base_q <= cfg_wdata_i[ID_W-1:0];
      end
      free_depth_q <= free_depth_d;
      used_depth_q <= used_depth_d;
      free_vld_q   <= free_vld_d;
      rd_idx_q     <= rd_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      done_q       <= ctrl_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) id_q <= handle_id_i;
    cmp_idx_q <= cmp_idx_d;
    if (ctrl_i.scan && hit) begin
      hit_pos_q  <= cmp_idx_q;
      hit_slot_q <= used_rd_q;
    end
    if (ctrl_i.fin) begin
      ok_q       <= res_ok;
      out_id_q   <= res_id;
      slot_q     <= res_slot;
      used_tot_q <= used_depth_d;
      free_tot_q <= free_depth_d;
    end
  end

  // Free stack memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acq_rd) begin
      free_rd_q      <= free_mem[free_top[SLOT_W-1:0]];
      free_rd_vld_q  <= free_vld_q[free_top[SLOT_W-1:0]];
      free_rd_addr_q <= free_top[SLOT_W-1:0];
    end
    if (free_we) free_mem[free_depth_q[SLOT_W-1:0]] <= push_slot;
  end

  // Used list memory
  always_ff @(posedge clk_i) begin
    if (used_re) used_rd_q <= used_mem[used_raddr];
    if (used_we) used_mem[used_waddr] <= used_wdata;
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign out_id_o     = out_id_q;
  assign slot_index_o = slot_q;
  assign used_total_o = used_tot_q;
  assign free_total_o = free_tot_q;

endmodule

`default_nettype wire

// File: rtl/buffer_handle_pool.sv
`default_nettype none

// Handle pool: a free stack and an unordered used list of slots, ids counted
// from base_id. Issue a command by raising start while busy is low; that edge
// takes the beat with command_i and handle_id_i. busy stays high until the
// command completes, and done_o then pulses for one cycle with the result on
// ok_o, out_id_o, slot_index_o, used_total_o and free_total_o. The receiver
// cannot stall: sample the result in the done_o cycle. A new command may be
// issued in that same cycle.
// Init, unknown commands, a failed acquire, and a flush or any search of an
// empty list complete without leaving idle; acquire passes through S_ACQ. Find
// and release scan the used list up to the match, release then reading the
// last entry and moving it into the hole; a miss of either, and a flush, scan
// the whole used list. The single read port of the used-list memory, read one
// entry a cycle, sets the search and flush length.
// Write pool_capacity (index 0) and base_id (index 1) through cfg_we_i while
// idle; capacity takes effect at the next init, base at once.
// Reset leaves a full free stack of the built depth, an empty used list,
// capacity 64 and base 1; no clearing pass is needed.
module buffer_handle_pool (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bhp_pkg::CMD_W-1:0]      command_i,
  input  logic [bhp_pkg::ID_W-1:0]       handle_id_i,
  input  logic                          cfg_we_i,
  input  logic [bhp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bhp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [bhp_pkg::ID_W-1:0]       out_id_o,
  output logic [bhp_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [bhp_pkg::CNT_W-1:0]      used_total_o,
  output logic [bhp_pkg::CNT_W-1:0]      free_total_o
);
  import bhp_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Sequence each command; the controller sees start, the command and status flags only
  bhp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .status_i  (status),
    .ctrl_o    (ctrl),
    .busy      (busy)
  );

  // Hold the stack, the list, the counters and the result registers
  bhp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .handle_id_i  (handle_id_i),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .out_id_o     (out_id_o),
    .slot_index_o (slot_index_o),
    .used_total_o (used_total_o),
    .free_total_o (free_total_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/bhp_pool_checker.sv
`timescale 1ns / 1ps

module bhp_pool_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [bhp_pkg::CMD_W-1:0]      command_i,
  input  logic [bhp_pkg::ID_W-1:0]       handle_id_i,
  input  logic                           cfg_we_i,
  input  logic [bhp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bhp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           done_i,
  input  logic                           ok_i,
  input  logic [bhp_pkg::ID_W-1:0]       out_id_i,
  input  logic [bhp_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic [bhp_pkg::CNT_W-1:0]      used_total_i,
  input  logic [bhp_pkg::CNT_W-1:0]      free_total_i,
  output int                             pending_o,
  output int                             fail_count_o
);
  import bhp_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } pool_result_t;

  // Shadow pool: free stack, unordered used list and the two registers
  logic [SLOT_W-1:0] free_slots [POOL_DEPTH];
  logic [SLOT_W-1:0] used_slots [POOL_DEPTH];
  logic [CNT_W-1:0]  free_cnt;
  logic [CNT_W-1:0]  used_cnt;
  logic [CAP_W-1:0]  cap_reg;
  logic [ID_W-1:0]   base_reg;

  pool_result_t due_results [$];
  pool_result_t want;
  int           errs;

  function automatic int locate_used(input logic [ID_W-1:0] id);
    int pos;
    logic [ID_W-1:0] cand;
    pos = -1;
    for (int i = 0; i < int'(used_cnt); i++) begin
      cand = base_reg + ID_W'(used_slots[i]);
      if (pos < 0 && cand == id) pos = i;
    end
    return pos;
  endfunction

  function automatic void push_free(input logic [SLOT_W-1:0] s);
    if (free_cnt < POOL_DEPTH) begin
      free_slots[free_cnt[SLOT_W-1:0]] = s;
      free_cnt = free_cnt + 1'b1;
    end
  endfunction

  // Apply one command to the shadow pool and return the result it yields
  function automatic pool_result_t apply_pool_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id);
    pool_result_t r;
    int pos;
    logic [SLOT_W-1:0] s;
    r = '0;
    case (cmd)
      CMD_ACQUIRE: begin
        if (free_cnt > 0 && used_cnt < POOL_DEPTH) begin
          free_cnt = free_cnt - 1'b1;
          s = free_slots[free_cnt[SLOT_W-1:0]];
          used_slots[used_cnt[SLOT_W-1:0]] = s;
          used_cnt = used_cnt + 1'b1;
          r.ok = 1'b1;
          r.slot = s;
          r.id = base_reg + ID_W'(s);
        end
      end
      CMD_FIND: begin
        pos = locate_used(id);
        if (pos >= 0) begin
          r.ok = 1'b1;
          r.slot = used_slots[pos];
          r.id = id;
        end
      end
      CMD_RELEASE: begin
        pos = locate_used(id);
        if (pos >= 0) begin
          s = used_slots[pos];
          used_cnt = used_cnt - 1'b1;
          used_slots[pos] = used_slots[used_cnt[SLOT_W-1:0]];
          push_free(s);
          r.ok = 1'b1;
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < int'(used_cnt); i++) push_free(used_slots[i]);
        used_cnt = '0;
        r.ok = 1'b1;
      end
      CMD_INIT: begin
        for (int i = 0; i < POOL_DEPTH; i++) free_slots[i] = SLOT_W'(i);
        free_cnt = (cap_reg > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : CNT_W'(cap_reg);
        used_cnt = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.used = used_cnt;
    r.free = free_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ID_W-1:0] exp_val,
                             input logic [ID_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        free_slots[i] = SLOT_W'(i);
        used_slots[i] = '0;
      end
      free_cnt = CNT_W'(POOL_DEPTH);
      used_cnt = '0;
      cap_reg  = CAP_RESET;
      base_reg = BASE_RESET;
      due_results.delete();
      errs = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Retire the result beat first; a new command beat on this edge queues behind it
      if (done_i) begin
        if (due_results.size() == 0) begin
          $error("result beat with no command outstanding");
          errs++;
        end else begin
          want = due_results.pop_front();
          check_field("ok", ID_W'(want.ok), ID_W'(ok_i));
          check_field("out_id", want.id, out_id_i);
          check_field("slot_index", ID_W'(want.slot), ID_W'(slot_index_i));
          check_field("used_total", ID_W'(want.used), ID_W'(used_total_i));
          check_field("free_total", ID_W'(want.free), ID_W'(free_total_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: cap_reg = cfg_wdata_i[CAP_W-1:0];
          REG_BASE:     base_reg = cfg_wdata_i[ID_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) due_results.push_back(apply_pool_command(command_i, handle_id_i));
      pending_o    <= due_results.size();
      fail_count_o <= errs;
    end
  end

endmodule

// File: tb/sv/tb_buffer_handle_pool.sv
`timescale 1ns / 1ps

module tb_buffer_handle_pool;
  import bhp_pkg::*;

  // Cycles with no beat on either side before the run is declared hung
  localparam int STALL_LIMIT   = 2000;
  // Longest command (full-pool search) plus margin
  localparam int SETTLE_CYCLES = 80;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_BEATS = 117;

  localparam logic [CMD_W-1:0]     CMD_BAD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_BAD_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 2'd3;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      command     = '0;
  logic [ID_W-1:0]       handle_id   = '0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  done_o;
  logic                  ok_o;
  logic [ID_W-1:0]       out_id_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [CNT_W-1:0]      used_total_o;
  logic [CNT_W-1:0]      free_total_o;

  int pending;
  int fail_count;
  int stall_cycles;
  // Percent chance per cycle that the sender holds start low
  int idle_pct;
  // Base id as last written; used to aim find and release at live handles
  logic [ID_W-1:0] cur_base;

  buffer_handle_pool u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command),
    .handle_id_i  (handle_id),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .out_id_o     (out_id_o),
    .slot_index_o (slot_index_o),
    .used_total_o (used_total_o),
    .free_total_o (free_total_o)
  );

  bhp_pool_checker u_pool_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .command_i    (command),
    .handle_id_i  (handle_id),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .done_i       (done_o),
    .ok_i         (ok_o),
    .out_id_i     (out_id_o),
    .slot_index_i (slot_index_o),
    .used_total_i (used_total_o),
    .free_total_i (free_total_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Count cycles in which no beat moves on either side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    @(posedge clk_i);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Issue one command beat; return at the edge that takes it. Start is left high
  // so a back-to-back beat does not toggle it within one step.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] hid);
    if ($urandom_range(0, 99) < idle_pct) begin
      start     <= 1'b0;
      command   <= CMD_W'($urandom());
      handle_id <= $urandom();
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    start     <= 1'b1;
    command   <= cmd;
    handle_id <= hid;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off new commands until every outstanding result has come back
  task automatic drain_pool();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One register write; the trailing idle edge keeps the enable from being
  // dropped and raised in the same step by a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int pick;
    int slot;
    int span;
    int acq_w;
    int cap_low;
    logic [CMD_W-1:0]      cmd;
    logic [ID_W-1:0]       hid;
    logic [CFG_DATA_W-1:0] cap_word;
    logic [CFG_DATA_W-1:0] base_word;

    idle_pct = 21;
    cur_base = BASE_RESET;
    span     = POOL_DEPTH;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset pool is full with base 1, so the first acquire pops slot 63
    send_beat(CMD_FIND, 32'd1);          // search of an empty used list
    send_beat(CMD_RELEASE, 32'd1);
    send_beat(CMD_ACQUIRE, 32'hFFFF_FFFF);
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_FIND, 32'd64);
    send_beat(CMD_FIND, 32'hFFFF_FFFF);
    send_beat(CMD_RELEASE, 32'd63);
    send_beat(CMD_RELEASE, 32'd63);      // already returned: no effect
    send_beat(CMD_BAD_FIRST, 32'h0);
    send_beat(CMD_INIT + 3'd2, 32'hFFFF_FFFF);
    send_beat(CMD_BAD_LAST, $urandom());
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_FLUSH, 32'hFFFF_FFFF);
    send_beat(CMD_INIT, 32'h0);

    // Capacity zero: every acquire fails after init
    drain_pool();
    write_reg(REG_CAPACITY, 32'hFFFF_FF80);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    cur_base = 32'hFFFF_FFFF;
    send_beat(CMD_INIT, 32'h0);
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_FIND, 32'hFFFF_FFFF);

    // Capacity above depth saturates; ids wrap past the top of the id space
    drain_pool();
    write_reg(REG_CAPACITY, 32'h0000_007F);
    send_beat(CMD_INIT, 32'h0);
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_FIND, 32'h0000_003E);

    // Base change renames live handles at once
    drain_pool();
    write_reg(REG_BASE, 32'h0);
    cur_base = 32'h0;
    send_beat(CMD_FIND, 32'h0000_003F);
    send_beat(CMD_RELEASE, 32'h0000_003F);

    // Single-handle pool
    drain_pool();
    write_reg(REG_CAPACITY, 32'd1);
    send_beat(CMD_INIT, 32'h0);
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_ACQUIRE, 32'h0);
    send_beat(CMD_RELEASE, 32'h0);

    // Random segments: four per idling phase, each under a fresh pool setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0:       idle_pct = 21;
        1:       idle_pct = 81;
        default: idle_pct = 0;
      endcase
      drain_pool();
      case (seg % 6)
        0:       cap_low = POOL_DEPTH;
        1:       cap_low = $urandom_range(2, 8);
        2:       cap_low = 127;
        3:       cap_low = $urandom_range(1, POOL_DEPTH);
        4:       cap_low = (seg == 4) ? 0 : 1;
        default: cap_low = POOL_DEPTH;
      endcase
      case (seg % 6)
        0:       base_word = 32'h0;
        1:       base_word = 32'hFFFF_FFFF;
        2:       base_word = 32'hFFFF_FFE0;
        4:       base_word = 32'h1;
        default: base_word = $urandom();
      endcase
      // Upper data bits are don't-care for the capacity register; toggle them
      cap_word = ($urandom() & 32'hFFFF_FF80) | CFG_DATA_W'(cap_low);
      write_reg(REG_CAPACITY, cap_word);
      write_reg(REG_BASE, base_word);
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
      cur_base = base_word;
      span = (cap_low > POOL_DEPTH) ? POOL_DEPTH : cap_low;
      send_beat(CMD_INIT, $urandom());
      acq_w = 30 + 20 * $urandom_range(0, 2);

      for (int n = 0; n < SEGMENT_BEATS; n++) begin
        // Rename the pool mid-segment with handles still live
        if (n == SEGMENT_BEATS / 2 && seg % 3 == 1) begin
          drain_pool();
          base_word = $urandom();
          write_reg(REG_BASE, base_word);
          cur_base = base_word;
        end
        pick = $urandom_range(0, 99);
        slot = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, POOL_DEPTH - 1);
        hid  = cur_base + ID_W'(slot);
        if (pick < acq_w) begin
          cmd = CMD_ACQUIRE;
          hid = $urandom();
        end else if (pick < acq_w + (100 - acq_w) / 2) begin
          cmd = CMD_RELEASE;
        end else if (pick < acq_w + (100 - acq_w) * 8 / 10) begin
          cmd = CMD_FIND;
        end else if (pick < acq_w + (100 - acq_w) * 93 / 100) begin
          // Ids that cannot be live: fully random, past the last slot, or just below base
          cmd = $urandom_range(0, 1) ? CMD_FIND : CMD_RELEASE;
          case ($urandom_range(0, 2))
            0:       hid = $urandom();
            1:       hid = cur_base + ID_W'(POOL_DEPTH + $urandom_range(0, 63));
            default: hid = cur_base - 1'b1;
          endcase
        end else begin
          hid = $urandom();
          case ($urandom_range(0, 3))
            0:       cmd = CMD_FLUSH;
            1:       cmd = CMD_INIT;
            default: cmd = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
          endcase
        end
        send_beat(cmd, hid);
      end
    end

    // Drop start, wait out every result, then let the block settle
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
